// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the checker of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clk edge outside of reset.
`define POC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen at a rising clk edge outside of reset.
`define POC_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== hw/rtl/poc_pkg.sv =====
// Package with the constants and word types of the order crossover block.
`timescale 1ns / 1ps

package poc_pkg;

  localparam int MAX_GENES = 64;
  localparam int GENE_BITS = 20;
  localparam int CUT_BITS  = 6;
  localparam int IDX_BITS  = $clog2(MAX_GENES);
  localparam int CNT_BITS  = $clog2(MAX_GENES + 1);
  localparam int WIDE_BITS = (CUT_BITS > CNT_BITS) ? CUT_BITS : CNT_BITS;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_RUN  = 1'b1;

  typedef struct packed {
    logic                 opcode;
    logic [GENE_BITS-1:0] gene_a;
    logic [GENE_BITS-1:0] gene_b;
    logic [CUT_BITS-1:0]  cut_first;
    logic [CUT_BITS-1:0]  cut_second;
  } in_word_t;

  typedef struct packed {
    logic [GENE_BITS-1:0] child_a_gene;
    logic [GENE_BITS-1:0] child_b_gene;
    logic [CUT_BITS-1:0]  position;
    logic                 last;
  } out_word_t;

  // Read addresses into the parent stores: port 1 is shared, port 2 is per parent.
  typedef struct packed {
    logic [IDX_BITS-1:0] addr1;
    logic [IDX_BITS-1:0] addr2_a;
    logic [IDX_BITS-1:0] addr2_b;
  } rd_req_t;

  typedef struct packed {
    logic [GENE_BITS-1:0] a1;
    logic [GENE_BITS-1:0] b1;
    logic [GENE_BITS-1:0] a2;
    logic [GENE_BITS-1:0] b2;
  } rd_data_t;

endpackage

// ===== hw/rtl/poc_parent_store.sv =====
// Parent A and parent B gene memories, one write port and two registered read ports each.
`timescale 1ns / 1ps

module poc_parent_store
  import poc_pkg::*;
(
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [IDX_BITS-1:0]  wr_addr,
  input  logic [GENE_BITS-1:0] wr_gene_a,
  input  logic [GENE_BITS-1:0] wr_gene_b,
  input  rd_req_t              rd_req,
  output rd_data_t             rd_data
);

  logic [GENE_BITS-1:0] mem_a [MAX_GENES];
  logic [GENE_BITS-1:0] mem_b [MAX_GENES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_a[wr_addr] <= wr_gene_a;
      mem_b[wr_addr] <= wr_gene_b;
    end
    rd_data.a1 <= mem_a[rd_req.addr1];
    rd_data.b1 <= mem_b[rd_req.addr1];
    rd_data.a2 <= mem_a[rd_req.addr2_a];
    rd_data.b2 <= mem_b[rd_req.addr2_b];
  end

endmodule

// ===== hw/rtl/permutation_order_crossover.sv =====
// Top level of the two-point order crossover engine for permutation chromosomes.
`timescale 1ns / 1ps

// A load word (opcode 0) stores one gene of each parent at the next position;
// busy stays low, and loads past the store depth are dropped. A run word
// (opcode 1) orders and clamps the two cuts, then marks, with one shared
// equality compare per parent, every gene that matches a gene of the other
// parent's middle segment: a single comparator walks the whole loaded
// chromosome for each middle gene. The emit pass then produces one result
// word per position, each through a seek step and an output step; the seek
// step repeats while the cursors pass over dropped genes (both cursors step
// in the same cycle). A run with nothing loaded produces no result and leaves
// busy low. Each result word is shown for exactly one cycle on out_word with
// out_valid high; the receiver cannot stall it and must take it then. busy
// is high from the cycle after a run is accepted and goes low in the cycle in
// which the last result is shown; the gene count is cleared at the end of a
// run.
module permutation_order_crossover
  import poc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_word_t  in_word,
  output logic      out_valid,
  output out_word_t out_word
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MARK,
    S_DRAIN,
    S_SEEK,
    S_OUT
  } state_t;

  state_t                state_r;
  logic [CNT_BITS-1:0]   count_r;
  logic [IDX_BITS-1:0]   lo_r;
  logic [IDX_BITS-1:0]   hi_r;
  logic [IDX_BITS-1:0]   i_r;
  logic [IDX_BITS-1:0]   j_r;
  logic [IDX_BITS-1:0]   p_r;
  logic [CNT_BITS-1:0]   ca_r;
  logic [CNT_BITS-1:0]   cb_r;
  logic                  mid_r;
  logic                  zero_a_r;
  logic                  zero_b_r;
  logic                  mark_v_r;
  logic [IDX_BITS-1:0]   mark_j_r;
  logic                  out_valid_r;
  out_word_t             out_word_r;
  logic [MAX_GENES-1:0]  keep_a_r;
  logic [MAX_GENES-1:0]  keep_b_r;

  logic                  accept;
  logic                  load_ok;
  logic [CNT_BITS-1:0]   cnt_m1;
  logic [WIDE_BITS-1:0]  cnt_w;
  logic [WIDE_BITS-1:0]  cut1_w;
  logic [WIDE_BITS-1:0]  cut2_w;
  logic [IDX_BITS-1:0]   sat1;
  logic [IDX_BITS-1:0]   sat2;
  logic                  j_last;
  logic                  p_last;
  logic                  p_mid;
  logic                  a_done;
  logic                  b_done;
  logic                  a_ok;
  logic                  b_ok;
  logic                  clear_marks;
  rd_req_t               rd_req;
  rd_data_t              rd_data;

  assign accept  = start && (state_r == S_IDLE);
  assign load_ok = accept && (in_word.opcode == OP_LOAD) &&
                   (count_r < CNT_BITS'(MAX_GENES));
  assign cnt_m1  = count_r - CNT_BITS'(1);

  // Cuts at or beyond the loaded length saturate to the last position.
  assign cnt_w  = WIDE_BITS'(count_r);
  assign cut1_w = WIDE_BITS'(in_word.cut_first);
  assign cut2_w = WIDE_BITS'(in_word.cut_second);
  assign sat1   = (cut1_w >= cnt_w) ? IDX_BITS'(cnt_w - WIDE_BITS'(1)) : IDX_BITS'(cut1_w);
  assign sat2   = (cut2_w >= cnt_w) ? IDX_BITS'(cnt_w - WIDE_BITS'(1)) : IDX_BITS'(cut2_w);

  assign j_last = (CNT_BITS'(j_r) == cnt_m1);
  assign p_last = (CNT_BITS'(p_r) == cnt_m1);
  assign p_mid  = (p_r >= lo_r) && (p_r <= hi_r);

  // A cursor is settled when it sits on a kept gene or has run off the end.
  assign a_done = (ca_r >= count_r);
  assign b_done = (cb_r >= count_r);
  assign a_ok   = a_done || keep_a_r[ca_r[IDX_BITS-1:0]];
  assign b_ok   = b_done || keep_b_r[cb_r[IDX_BITS-1:0]];

  assign clear_marks = (state_r == S_OUT) && p_last;

  // During marking, port 1 reads the middle gene and port 2 walks the chromosome.
  // During emitting, port 1 reads the current position and port 2 the cursors.
  always_comb begin
    rd_req.addr1   = (state_r == S_MARK) ? i_r : p_r;
    rd_req.addr2_a = (state_r == S_MARK) ? j_r : ca_r[IDX_BITS-1:0];
    rd_req.addr2_b = (state_r == S_MARK) ? j_r : cb_r[IDX_BITS-1:0];
  end

  poc_parent_store u_store (
    .clk       (clk),
    .wr_en     (load_ok),
    .wr_addr   (count_r[IDX_BITS-1:0]),
    .wr_gene_a (in_word.gene_a),
    .wr_gene_b (in_word.gene_b),
    .rd_req    (rd_req),
    .rd_data   (rd_data)
  );

  // Keep marks: the compare stage, working on the read data in the cycle after
  // the read addresses, clears any gene that equals the other parent's current middle gene.
  always_ff @(posedge clk) begin
    if (!rst_n || clear_marks) begin
      keep_a_r <= '1;
      keep_b_r <= '1;
    end else if (mark_v_r) begin
      if (rd_data.a2 == rd_data.b1) begin
        keep_a_r[mark_j_r] <= 1'b0;
      end
      if (rd_data.b2 == rd_data.a1) begin
        keep_b_r[mark_j_r] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      mark_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      mark_v_r    <= (state_r == S_MARK);
      mark_j_r    <= j_r;
      unique case (state_r)
        S_IDLE: begin
          if (load_ok) begin
            count_r <= count_r + CNT_BITS'(1);
          end else if (accept && (in_word.opcode == OP_RUN) && (count_r != '0)) begin
            lo_r    <= (sat1 <= sat2) ? sat1 : sat2;
            hi_r    <= (sat1 <= sat2) ? sat2 : sat1;
            i_r     <= (sat1 <= sat2) ? sat1 : sat2;
            j_r     <= '0;
            state_r <= S_MARK;
          end
        end
        S_MARK: begin
          if (j_last) begin
            j_r <= '0;
            if (i_r == hi_r) begin
              state_r <= S_DRAIN;
            end else begin
              i_r <= i_r + IDX_BITS'(1);
            end
          end else begin
            j_r <= j_r + IDX_BITS'(1);
          end
        end
        S_DRAIN: begin
          p_r     <= '0;
          ca_r    <= '0;
          cb_r    <= '0;
          state_r <= S_SEEK;
        end
        S_SEEK: begin
          if (p_mid) begin
            mid_r   <= 1'b1;
            state_r <= S_OUT;
          end else if (a_ok && b_ok) begin
            mid_r    <= 1'b0;
            zero_a_r <= a_done;
            zero_b_r <= b_done;
            if (!a_done) begin
              ca_r <= ca_r + CNT_BITS'(1);
            end
            if (!b_done) begin
              cb_r <= cb_r + CNT_BITS'(1);
            end
            state_r <= S_OUT;
          end else begin
            if (!a_ok) begin
              ca_r <= ca_r + CNT_BITS'(1);
            end
            if (!b_ok) begin
              cb_r <= cb_r + CNT_BITS'(1);
            end
          end
        end
        S_OUT: begin
          out_valid_r <= 1'b1;
          out_word_r.child_a_gene <= mid_r ? rd_data.b1 : (zero_a_r ? '0 : rd_data.a2);
          out_word_r.child_b_gene <= mid_r ? rd_data.a1 : (zero_b_r ? '0 : rd_data.b2);
          out_word_r.position     <= CUT_BITS'(p_r);
          out_word_r.last         <= p_last;
          if (p_last) begin
            count_r <= '0;
            state_r <= S_IDLE;
          end else begin
            p_r     <= p_r + IDX_BITS'(1);
            state_r <= S_SEEK;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

// ===== hw/rtl/poc_checker.sv =====
// Port-level checker for the order crossover block and its bind statement.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module poc_checker
  import poc_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input in_word_t  in_word,
  input logic      out_valid,
  input out_word_t out_word
);

  // Every result but the final one arrives while the run is still going.
  `POC_ASSERT(a_mid_result_busy, (out_valid && !out_word.last) |-> busy, "result outside a run")

  // The final result ends the run unless a new word is taken at once.
  `POC_ASSERT(a_last_ends_run, (out_valid && out_word.last && !start) |=> !busy, "run did not end")

  // Each position passes through the seek state, so strobes never come back to back.
  `POC_NEVER(a_no_double_strobe, out_valid && $past(out_valid), "back-to-back results")

  // A run starts only from an accepted run word.
  `POC_ASSERT(a_busy_from_run, $rose(busy) |-> $past(start && !busy && in_word.opcode == OP_RUN),
              "busy without a run word")

endmodule

bind permutation_order_crossover poc_checker u_poc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_word   (in_word),
  .out_valid (out_valid),
  .out_word  (out_word)
);
